// ===== rtl/core/tkd_pkg.sv =====
// Package for the tick task dispatcher: sizes, codes and controller/datapath link types.
`timescale 1ns / 1ps
`default_nettype none
package tkd_pkg;

	localparam int TASK_SLOTS = 8;
	localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
	localparam int ID_W       = 4;
	localparam int DIV_STEPS  = 8;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_EXISTS  = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_ABSENT  = 3'd4;
	localparam logic [2:0] ST_EMPTY   = 3'd5;

	localparam logic [7:0] MODE_PERIODIC = 8'd1;

	typedef struct packed {
		logic load;
		logic emit_status;
		logic div_start;
		logic div_step;
		logic commit;
		logic apply_delete;
		logic scan_init;
		logic scan_step;
		logic flush;
	} tkd_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       create_ok;
		logic       div_last;
		logic       scan_last;
	} tkd_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/tkd_ctrl.sv =====
// Controller state machine of the tick task dispatcher.
`timescale 1ns / 1ps
`default_nettype none
module tkd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  tkd_pkg::tkd_stat_t    stat,
	output tkd_pkg::tkd_cmd_t     cmd,
	output logic                  busy
);
	import tkd_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_COMMIT = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_FLUSH  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.op)
					OP_CREATE: begin
						if (stat.create_ok) begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end else begin
							cmd.emit_status = 1'b1;
							state_d         = S_IDLE;
						end
					end
					OP_DELETE: begin
						cmd.emit_status  = 1'b1;
						cmd.apply_delete = 1'b1;
						state_d          = S_IDLE;
					end
					OP_TICK: begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
					default: begin
						cmd.emit_status = 1'b1;
						state_d         = S_IDLE;
					end
				endcase
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit      = 1'b1;
				cmd.emit_status = 1'b1;
				state_d         = S_IDLE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/tkd_datapath.sv =====
// Datapath of the tick task dispatcher: slot table, delay divider, tick scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module tkd_datapath (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [1:0]              opcode,
	input  wire logic [7:0]              task_id,
	input  wire logic [7:0]              periodic_mode,
	input  wire logic [7:0]              delay_time,
	input  wire logic [7:0]              ticks_elapsed,
	input  wire logic [7:0]              resolution,
	input  tkd_pkg::tkd_cmd_t            cmd,
	output tkd_pkg::tkd_stat_t           stat,
	output logic                         result_valid,
	output logic [2:0]                   status,
	output logic                         due_valid,
	output logic [tkd_pkg::ID_W-1:0]     due_id,
	output logic                         last
);
	import tkd_pkg::*;

	// Latched item.
	logic [1:0] op_q;
	logic [7:0] id_q;
	logic [7:0] mode_q;
	logic [7:0] delay_q;
	logic [7:0] ticks_q;

	// Slot table.
	logic [TASK_SLOTS-1:0] valid_q;
	logic [TASK_SLOTS-1:0] periodic_q;
	logic [7:0]            target_q  [TASK_SLOTS];
	logic [7:0]            elapsed_q [TASK_SLOTS];
	logic [CNT_W-1:0]      count_q;

	// Divider.
	logic [7:0]           divisor_q;
	logic [7:0]           quo_q;
	logic [7:0]           rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [8:0]           div_shift;
	logic                 div_fit;

	// Scan.
	logic [SLOT_W-1:0] scan_idx_q;
	logic              pend_q;
	logic [SLOT_W-1:0] pend_id_q;
	logic [8:0]        scan_sum;
	logic [7:0]        scan_sat;
	logic              scan_due;

	// Result register.
	logic            res_valid_q;
	logic [2:0]      status_q;
	logic            due_valid_q;
	logic [ID_W-1:0] due_id_q;
	logic            last_q;

	logic              id_in_range;
	logic [SLOT_W-1:0] sid;
	logic              slot_used;
	logic [2:0]        create_status;
	logic [2:0]        delete_status;
	logic [2:0]        item_status;

	assign id_in_range = (id_q < 8'(TASK_SLOTS));
	assign sid         = id_q[SLOT_W-1:0];
	assign slot_used   = id_in_range && valid_q[sid];

	always_comb begin
		if (count_q == CNT_W'(TASK_SLOTS)) begin
			create_status = ST_FULL;
		end else if (!id_in_range) begin
			create_status = ST_INVALID;
		end else if (slot_used) begin
			create_status = ST_EXISTS;
		end else if (mode_q > MODE_PERIODIC) begin
			create_status = ST_INVALID;
		end else begin
			create_status = ST_OK;
		end

		if (count_q == '0) begin
			delete_status = ST_EMPTY;
		end else if (!id_in_range) begin
			delete_status = ST_INVALID;
		end else if (!slot_used) begin
			delete_status = ST_ABSENT;
		end else begin
			delete_status = ST_OK;
		end

		case (op_q)
			OP_CREATE: item_status = create_status;
			OP_DELETE: item_status = delete_status;
			default:   item_status = ST_INVALID;
		endcase
	end

	// One restoring step: shift in the next dividend bit and subtract if it fits.
	assign div_shift = {rem_q, quo_q[7]};
	assign div_fit   = (div_shift >= {1'b0, divisor_q});

	assign scan_sum = {1'b0, elapsed_q[scan_idx_q]} + {1'b0, ticks_q};
	assign scan_sat = scan_sum[8] ? 8'hFF : scan_sum[7:0];
	assign scan_due = valid_q[scan_idx_q] && (scan_sat >= target_q[scan_idx_q]);

	assign stat.op        = op_q;
	assign stat.create_ok = (create_status == ST_OK);
	assign stat.div_last  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign stat.scan_last = (scan_idx_q == SLOT_W'(TASK_SLOTS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			id_q    <= task_id;
			mode_q  <= periodic_mode;
			delay_q <= delay_time;
			ticks_q <= ticks_elapsed;
		end
		if (cmd.div_start) begin
			divisor_q <= (resolution == 8'd0) ? 8'd1 : resolution;
			quo_q     <= delay_q;
			rem_q     <= 8'd0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[6:0], div_fit};
			rem_q <= div_fit ? 8'(div_shift - {1'b0, divisor_q}) : div_shift[7:0];
		end
		if (cmd.commit) begin
			periodic_q[sid] <= (mode_q == MODE_PERIODIC);
			target_q[sid]   <= quo_q;
			elapsed_q[sid]  <= 8'd0;
		end
		if (cmd.scan_step && valid_q[scan_idx_q]) begin
			elapsed_q[scan_idx_q] <= (scan_due && periodic_q[scan_idx_q]) ? 8'd0 : scan_sat;
		end
		if (cmd.scan_step && scan_due) begin
			pend_id_q <= scan_idx_q;
		end
		if (cmd.emit_status) begin
			status_q    <= item_status;
			due_valid_q <= 1'b0;
			due_id_q    <= '0;
			last_q      <= 1'b1;
		end else if (cmd.scan_step) begin
			status_q    <= ST_OK;
			due_valid_q <= 1'b1;
			due_id_q    <= ID_W'(pend_id_q);
			last_q      <= 1'b0;
		end else if (cmd.flush) begin
			status_q    <= ST_OK;
			due_valid_q <= pend_q;
			due_id_q    <= pend_q ? ID_W'(pend_id_q) : '0;
			last_q      <= 1'b1;
		end else begin
			status_q    <= ST_OK;
			due_valid_q <= 1'b0;
			due_id_q    <= '0;
			last_q      <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			count_q     <= '0;
			div_cnt_q   <= '0;
			scan_idx_q  <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.emit_status || cmd.flush ||
				(cmd.scan_step && scan_due && pend_q);
			if (cmd.div_start) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.commit) begin
				valid_q[sid] <= 1'b1;
				count_q      <= count_q + 1'b1;
			end
			if (cmd.apply_delete && (delete_status == ST_OK)) begin
				valid_q[sid] <= 1'b0;
				count_q      <= count_q - 1'b1;
			end
			if (cmd.scan_init) begin
				scan_idx_q <= '0;
				pend_q     <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (scan_due) begin
					pend_q <= 1'b1;
					if (!periodic_q[scan_idx_q]) begin
						valid_q[scan_idx_q] <= 1'b0;
						count_q             <= count_q - 1'b1;
					end
				end
			end
		end
	end

	assign result_valid = res_valid_q;
	assign status       = status_q;
	assign due_valid    = due_valid_q;
	assign due_id       = due_id_q;
	assign last         = last_q;

endmodule
`default_nettype wire

// ===== rtl/core/tick_task_dispatcher_top.sv =====
// Top level of the tick task dispatcher: resolution register, controller and datapath.
//
//   Channel   Signals                                          Direction
//   item      start, busy, opcode, task_id, periodic_mode,    in (busy out)
//             delay_time, ticks_elapsed
//   result    result_valid, status, due_valid, due_id, last   out
//   config    psel, penable, pwrite, paddr, pwdata,           in (prdata,
//             prdata, pready                                   pready out)
//
// An item is taken at a rising edge with start high and busy low. A create
// that passes its checks goes through a decode state, eight steps of the
// bit-serial delay divider and a commit state before its result is
// registered. A delete, an unused opcode or a rejected create gives its
// result from the decode state. A tick pass walks the slot table one slot a
// cycle and then passes a flush state. Reset clears the valid bits and
// occupancy count at once, so no clearing pass is needed. Results are
// shown for one cycle each under result_valid; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module tick_task_dispatcher_top (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// Item channel.
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [1:0]              opcode,
	input  wire logic [7:0]              task_id,
	input  wire logic [7:0]              periodic_mode,
	input  wire logic [7:0]              delay_time,
	input  wire logic [7:0]              ticks_elapsed,
	// Result channel.
	output logic                         result_valid,
	output logic [2:0]                   status,
	output logic                         due_valid,
	output logic [tkd_pkg::ID_W-1:0]     due_id,
	output logic                         last,
	// Configuration port.
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [2:0]              paddr,
	input  wire logic [31:0]             pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import tkd_pkg::*;

	// The only register, tick_resolution, sits at word index zero. The low
	// two address bits are the byte offset and are ignored.
	localparam logic REG_RESOLUTION = 1'b0;

	logic [7:0] resolution_q;
	logic       cfg_write;
	tkd_cmd_t   cmd;
	tkd_stat_t  stat;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_RESOLUTION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resolution_q <= 8'd1;
		end else if (cfg_write) begin
			resolution_q <= pwdata[7:0];
		end
	end

	// Reads beyond the register list return zero.
	assign prdata = (paddr[2] == REG_RESOLUTION) ? {24'd0, resolution_q} : 32'd0;

	// The controller sequences decode, divide, commit and the slot scan.
	tkd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the slot table and drives the registered results.
	tkd_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.opcode        (opcode),
		.task_id       (task_id),
		.periodic_mode (periodic_mode),
		.delay_time    (delay_time),
		.ticks_elapsed (ticks_elapsed),
		.resolution    (resolution_q),
		.cmd           (cmd),
		.stat          (stat),
		.result_valid  (result_valid),
		.status        (status),
		.due_valid     (due_valid),
		.due_id        (due_id),
		.last          (last)
	);

endmodule
`default_nettype wire

// ===== rtl/core/tkd_checker.sv =====
// Port-level checker for the tick task dispatcher and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tkd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       result_valid,
	input wire logic [2:0] status,
	input wire logic       due_valid,
	input wire logic       last
);
	import tkd_pkg::*;

	// An accepted item keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after an accepted item");

	// The final result of an item is never followed at once by another.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid)
		else $error("result right after a final result");

	// Only due tasks of a tick pass come in several results.
	a_plain_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !due_valid |-> last)
		else $error("result without a due task is not final");

	// A due task is always reported with status ok.
	a_due_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && due_valid |-> status == ST_OK)
		else $error("due task with an error status");

	// More results of the same item are still to come, so the block is busy.
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("idle while a tick pass is unfinished");

endmodule

bind tick_task_dispatcher_top tkd_checker u_tkd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.status       (status),
	.due_valid    (due_valid),
	.last         (last)
);
`default_nettype wire
